// File: design/wrd_pkg.sv
// ----------------------------------------------------------------------------
// wrd_pkg
// Shared types and codes for the work range dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none
package wrd_pkg;

    typedef enum logic [2:0] {
        OP_CONNECT    = 3'd0,
        OP_REGISTER   = 3'd1,
        OP_REQUEST    = 3'd2,
        OP_HEARTBEAT  = 3'd3,
        OP_CHECKPOINT = 3'd4,
        OP_RESULT     = 3'd5,
        OP_DISCONNECT = 3'd6,
        OP_TICK       = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        K_JOB       = 4'd0,
        K_ASSIGN    = 4'd1,
        K_STOP      = 4'd2,
        K_HB_REQ    = 4'd3,
        K_DEAD      = 4'd4,
        K_ACCEPTED  = 4'd5,
        K_REJECTED  = 4'd6,
        K_LOST      = 4'd7,
        K_FOUND     = 4'd8,
        K_EXHAUSTED = 4'd9
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RM,
        ST_RM_END,
        ST_RM_CMP,
        ST_RQ_REC_MIN,
        ST_RQ_REC_ADD,
        ST_RQ_REC_SUB,
        ST_RQ_CUR_CMP,
        ST_RQ_CUR_SUB,
        ST_RQ_CUR_MIN,
        ST_RQ_CUR_ADD,
        ST_RS_ADD,
        ST_SCAN,
        ST_EMIT
    } t_state;

    localparam logic [0:0] CFG_CHUNK_SIZE = 1'b0;
    localparam logic [0:0] CFG_TOTAL      = 1'b1;

endpackage
`default_nettype wire

// File: design/work_range_dispatcher.sv
// ----------------------------------------------------------------------------
// work_range_dispatcher
// Hands out index ranges to worker slots, tracks liveness and requeues ranges.
// ----------------------------------------------------------------------------
//  channel   | signals                                      | direction
//  in        | i_in_valid / o_in_stall, operation..found     | request in
//  out       | o_out_valid / i_out_stall, kind..last         | result out
//  cfg       | i_cfg_we, i_cfg_index, i_cfg_data             | write only
//
//  a request is decoded, runs its arithmetic steps and emits its result; tick
//  and stop broadcasts walk every used slot in order, and the range left to
//  a slot declared dead is requeued. all index arithmetic runs through one shared
//  adder/subtractor; range and recovery stores are rams with registered read.
//  synchronous reset clears flags, counters and the cursor; no clearing pass.
//  o_in_stall is high whenever the sequencer is busy; a stalled result holds.
// ----------------------------------------------------------------------------
`default_nettype none
module work_range_dispatcher #(
    parameter int MAX_SLOTS  = 64,
    parameter int INDEX_BITS = 48
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [2:0]            i_operation,
    input  wire logic [5:0]            i_worker,
    input  wire logic [INDEX_BITS-1:0] i_checkpoint_index,
    input  wire logic                  i_found,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [3:0]                 o_kind,
    output logic [5:0]                 o_worker_slot,
    output logic [INDEX_BITS-1:0]      o_range_start,
    output logic [INDEX_BITS-1:0]      o_range_count,
    output logic                       o_last,
    input  wire logic                  i_cfg_we,
    input  wire logic [0:0]            i_cfg_index,
    input  wire logic [INDEX_BITS-1:0] i_cfg_data
);
    import wrd_pkg::*;

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int WW = (CW > 6) ? CW : 6;
    localparam int IB = INDEX_BITS;

    t_state r_state, n_state;

    logic [IB-1:0] r_chunk, r_total;
    logic [MAX_SLOTS-1:0] r_reg, n_reg, r_gone, n_gone, r_pend, n_pend;
    logic [CW-1:0] r_used, n_used, r_depth, n_depth, r_idx, n_idx;
    logic [IB-1:0] r_next, n_next;
    logic r_found, n_found;

    // latched request
    t_op r_op, n_op;
    logic [5:0] r_w, n_w;
    logic [IB-1:0] r_cp, n_cp;
    logic r_fnd, n_fnd;

    logic [SW-1:0] r_slot, n_slot;
    logic r_scan, n_scan, r_stop_mode, n_stop_mode, r_head, n_head;
    logic [IB-1:0] r_a, n_a, r_st, n_st, r_cnt, n_cnt;

    // pending result
    t_kind r_pk, n_pk;
    logic [5:0] r_pslot, n_pslot;
    logic [IB-1:0] r_pst, n_pst, r_pcnt, n_pcnt;

    logic [3:0] r_o_kind, n_o_kind;
    logic [5:0] r_o_slot, n_o_slot;
    logic [IB-1:0] r_o_st, n_o_st, r_o_cnt, n_o_cnt;
    logic r_o_last, n_o_last, r_o_valid, n_o_valid;

    // ram ports
    logic [IB-1:0] ss_rd, sc_rd, ck_rd, ss_wd, sc_wd, ck_wd;
    logic ss_we, sc_we, ck_we, rec_we;
    logic [2*IB-1:0] rec_rd, rec_wd;
    logic [SW-1:0] rec_raddr, rec_waddr;

    logic [IB-1:0] alu_a, alu_b, alu_res;
    logic alu_sub, alu_borrow;

    logic [IB-1:0] csz;
    logic [MAX_SLOTS-1:0] qual, after;
    logic any_after, out_free, in_acc, bad_w;
    logic [SW-1:0] idx_slot;

    assign in_acc = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free = ~r_o_valid | ~i_out_stall;
    assign csz = (r_chunk == '0) ? IB'(1) : r_chunk;
    assign idx_slot = r_idx[SW-1:0];
    assign bad_w = WW'(r_w) >= WW'(r_used);
    assign rec_raddr = SW'(r_depth - CW'(1));

    always_comb begin
        for (int j = 0; j < MAX_SLOTS; j++) begin
            qual[j]  = (CW'(j) < r_used) & ~r_gone[j] &
                       (r_stop_mode ? (SW'(j) != r_slot) : r_reg[j]);
            after[j] = qual[j] & (r_head | (CW'(j) > r_idx));
        end
    end
    assign any_after = |after;

    wrd_ram #(.WIDTH(IB), .DEPTH(MAX_SLOTS)) u_slot_start (
        .i_clk(i_clk), .i_we(ss_we), .i_waddr(r_slot), .i_wdata(ss_wd),
        .i_raddr(r_slot), .o_rdata(ss_rd)
    );
    wrd_ram #(.WIDTH(IB), .DEPTH(MAX_SLOTS)) u_slot_count (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(r_slot), .i_wdata(sc_wd),
        .i_raddr(r_slot), .o_rdata(sc_rd)
    );
    wrd_ram #(.WIDTH(IB), .DEPTH(MAX_SLOTS)) u_slot_ckpt (
        .i_clk(i_clk), .i_we(ck_we), .i_waddr(r_slot), .i_wdata(ck_wd),
        .i_raddr(r_slot), .o_rdata(ck_rd)
    );
    wrd_ram #(.WIDTH(2*IB), .DEPTH(MAX_SLOTS)) u_recovery (
        .i_clk(i_clk), .i_we(rec_we), .i_waddr(rec_waddr), .i_wdata(rec_wd),
        .i_raddr(rec_raddr), .o_rdata(rec_rd)
    );

    wrd_alu #(.INDEX_BITS(IB)) u_alu (
        .i_a(alu_a), .i_b(alu_b), .i_sub(alu_sub),
        .o_res(alu_res), .o_borrow(alu_borrow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chunk     <= IB'(64'd1048576);
            r_total     <= IB'(64'hFFFF_FFFF_FFFF);
            r_reg       <= '0;
            r_gone      <= '0;
            r_pend      <= '0;
            r_used      <= '0;
            r_depth     <= '0;
            r_idx       <= '0;
            r_next      <= '0;
            r_found     <= 1'b0;
            r_scan      <= 1'b0;
            r_stop_mode <= 1'b0;
            r_head      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_reg       <= n_reg;
            r_gone      <= n_gone;
            r_pend      <= n_pend;
            r_used      <= n_used;
            r_depth     <= n_depth;
            r_idx       <= n_idx;
            r_next      <= n_next;
            r_found     <= n_found;
            r_scan      <= n_scan;
            r_stop_mode <= n_stop_mode;
            r_head      <= n_head;
            r_o_valid   <= n_o_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CHUNK_SIZE) begin
                    r_chunk <= i_cfg_data;
                end else begin
                    r_total <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_w      <= n_w;
        r_cp     <= n_cp;
        r_fnd    <= n_fnd;
        r_slot   <= n_slot;
        r_a      <= n_a;
        r_st     <= n_st;
        r_cnt    <= n_cnt;
        r_pk     <= n_pk;
        r_pslot  <= n_pslot;
        r_pst    <= n_pst;
        r_pcnt   <= n_pcnt;
        r_o_kind <= n_o_kind;
        r_o_slot <= n_o_slot;
        r_o_st   <= n_o_st;
        r_o_cnt  <= n_o_cnt;
        r_o_last <= n_o_last;
    end

    always_comb begin
        n_state = r_state;
        n_reg = r_reg; n_gone = r_gone; n_pend = r_pend;
        n_used = r_used; n_depth = r_depth; n_idx = r_idx;
        n_next = r_next; n_found = r_found;
        n_op = r_op; n_w = r_w; n_cp = r_cp; n_fnd = r_fnd;
        n_slot = r_slot; n_scan = r_scan; n_stop_mode = r_stop_mode; n_head = r_head;
        n_a = r_a; n_st = r_st; n_cnt = r_cnt;
        n_pk = r_pk; n_pslot = r_pslot; n_pst = r_pst; n_pcnt = r_pcnt;
        n_o_kind = r_o_kind; n_o_slot = r_o_slot; n_o_st = r_o_st;
        n_o_cnt = r_o_cnt; n_o_last = r_o_last;
        n_o_valid = r_o_valid & i_out_stall;
        alu_a = r_a; alu_b = r_cnt; alu_sub = 1'b0;
        ss_we = 1'b0; sc_we = 1'b0; ck_we = 1'b0; rec_we = 1'b0;
        ss_wd = r_st; sc_wd = r_cnt; ck_wd = r_st;
        rec_wd = {r_a, alu_res};
        rec_waddr = rec_raddr;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_op = t_op'(i_operation);
                    n_w = i_worker;
                    n_cp = i_checkpoint_index;
                    n_fnd = i_found;
                    n_slot = SW'(i_worker);
                    n_scan = 1'b0;
                    n_head = 1'b0;
                    n_stop_mode = 1'b0;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_pst = '0;
                n_pcnt = '0;
                n_pslot = r_w;
                n_state = ST_EMIT;
                if (r_op == OP_CONNECT) begin
                    if (r_used < CW'(MAX_SLOTS)) begin
                        n_reg[r_used[SW-1:0]] = 1'b0;
                        n_gone[r_used[SW-1:0]] = 1'b0;
                        n_pend[r_used[SW-1:0]] = 1'b0;
                        n_pk = K_ACCEPTED;
                        n_pslot = 6'(r_used);
                        n_used = r_used + CW'(1);
                    end else begin
                        n_pk = K_REJECTED;
                        n_pslot = '0;
                    end
                end else if (r_op == OP_TICK) begin
                    n_scan = 1'b1;
                    n_idx = '0;
                    n_state = ST_SCAN;
                end else if (bad_w || r_gone[r_slot]) begin
                    n_pk = K_REJECTED;
                end else if (r_op == OP_DISCONNECT) begin
                    n_state = ST_RM;
                end else if (!r_reg[r_slot]) begin
                    if (r_op == OP_REGISTER) begin
                        n_reg[r_slot] = 1'b1;
                        n_pk = K_JOB;
                    end else begin
                        n_state = ST_RM;
                    end
                end else begin
                    case (r_op)
                        OP_REGISTER: n_pk = K_REJECTED;
                        OP_REQUEST: begin
                            if (r_found) begin
                                n_pk = K_STOP;
                            end else if (r_depth != '0) begin
                                n_state = ST_RQ_REC_MIN;
                            end else begin
                                n_state = ST_RQ_CUR_CMP;
                            end
                        end
                        OP_HEARTBEAT: begin
                            n_pend[r_slot] = 1'b0;
                            n_pk = K_ACCEPTED;
                        end
                        OP_CHECKPOINT: begin
                            ck_we = 1'b1;
                            ck_wd = r_cp;
                            n_pend[r_slot] = 1'b0;
                            n_pk = K_ACCEPTED;
                        end
                        default: n_state = ST_RS_ADD;
                    endcase
                end
            end
            ST_RM: begin
                n_gone[r_slot] = 1'b1;
                n_pk = K_DEAD;
                n_pslot = 6'(r_slot);
                n_pst = '0;
                n_pcnt = '0;
                if (r_found || !r_reg[r_slot]) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_RM_END;
                end
            end
            ST_RM_END: begin
                alu_a = ss_rd;
                alu_b = sc_rd;
                n_a = alu_res;
                n_state = ST_RM_CMP;
            end
            ST_RM_CMP: begin
                alu_a = r_a;
                alu_b = ck_rd;
                alu_sub = 1'b1;
                n_state = ST_EMIT;
                // resume at or past the end: nothing left to requeue
                if (!alu_borrow && alu_res != '0) begin
                    n_pst = ck_rd;
                    n_pcnt = alu_res;
                    if (r_depth < CW'(MAX_SLOTS)) begin
                        rec_we = 1'b1;
                        rec_waddr = r_depth[SW-1:0];
                        rec_wd = {ck_rd, alu_res};
                        n_depth = r_depth + CW'(1);
                    end else begin
                        n_pk = K_LOST;
                    end
                end
            end
            ST_RQ_REC_MIN: begin
                alu_a = csz;
                alu_b = rec_rd[IB-1:0];
                alu_sub = 1'b1;
                n_st = rec_rd[2*IB-1:IB];
                n_cnt = alu_borrow ? csz : rec_rd[IB-1:0];
                n_state = ST_RQ_REC_ADD;
            end
            ST_RQ_REC_ADD: begin
                alu_a = r_st;
                alu_b = r_cnt;
                n_a = alu_res;
                n_state = ST_RQ_REC_SUB;
            end
            ST_RQ_REC_SUB: begin
                alu_a = rec_rd[IB-1:0];
                alu_b = r_cnt;
                alu_sub = 1'b1;
                rec_we = 1'b1;
                if (alu_res == '0) begin
                    n_depth = r_depth - CW'(1);
                end
                ss_we = 1'b1; sc_we = 1'b1; ck_we = 1'b1;
                n_pk = K_ASSIGN;
                n_pslot = 6'(r_slot);
                n_pst = r_st;
                n_pcnt = r_cnt;
                n_state = ST_EMIT;
            end
            ST_RQ_CUR_CMP: begin
                alu_a = r_next;
                alu_b = r_total;
                alu_sub = 1'b1;
                if (alu_borrow) begin
                    n_state = ST_RQ_CUR_SUB;
                end else begin
                    n_pk = K_EXHAUSTED;
                    n_state = ST_EMIT;
                end
            end
            ST_RQ_CUR_SUB: begin
                alu_a = r_total;
                alu_b = r_next;
                alu_sub = 1'b1;
                n_a = alu_res;
                n_state = ST_RQ_CUR_MIN;
            end
            ST_RQ_CUR_MIN: begin
                alu_a = csz;
                alu_b = r_a;
                alu_sub = 1'b1;
                n_cnt = alu_borrow ? csz : r_a;
                n_st = r_next;
                n_state = ST_RQ_CUR_ADD;
            end
            ST_RQ_CUR_ADD: begin
                alu_a = r_next;
                alu_b = r_cnt;
                n_next = alu_res;
                ss_we = 1'b1; sc_we = 1'b1; ck_we = 1'b1;
                n_pk = K_ASSIGN;
                n_pslot = 6'(r_slot);
                n_pst = r_st;
                n_pcnt = r_cnt;
                n_state = ST_EMIT;
            end
            ST_RS_ADD: begin
                alu_a = ss_rd;
                alu_b = sc_rd;
                ck_we = 1'b1;
                ck_wd = alu_res;
                n_state = ST_EMIT;
                if (!r_found && r_fnd) begin
                    n_found = 1'b1;
                    n_pk = K_FOUND;
                    n_scan = 1'b1;
                    n_stop_mode = 1'b1;
                    n_head = 1'b1;
                    n_idx = '0;
                end else begin
                    n_pk = K_ACCEPTED;
                end
            end
            ST_SCAN: begin
                n_pst = '0;
                n_pcnt = '0;
                n_pslot = 6'(idx_slot);
                if (r_idx >= r_used) begin
                    n_state = ST_IDLE;
                end else if (!qual[idx_slot]) begin
                    n_idx = r_idx + CW'(1);
                end else if (r_stop_mode) begin
                    n_pk = K_STOP;
                    n_state = ST_EMIT;
                end else if (r_pend[idx_slot]) begin
                    n_slot = idx_slot;
                    n_state = ST_RM;
                end else begin
                    n_pend[idx_slot] = 1'b1;
                    n_pk = K_HB_REQ;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind = r_pk;
                    n_o_slot = r_pslot;
                    n_o_st = r_pst;
                    n_o_cnt = r_pcnt;
                    n_o_last = r_scan ? ~any_after : 1'b1;
                    if (!r_scan) begin
                        n_state = ST_IDLE;
                    end else begin
                        // the found result opens the stop walk at slot zero
                        if (r_head) begin
                            n_head = 1'b0;
                        end else begin
                            n_idx = r_idx + CW'(1);
                        end
                        n_state = ST_SCAN;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid   = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_worker_slot = r_o_slot;
    assign o_range_start = r_o_st;
    assign o_range_count = r_o_cnt;
    assign o_last        = r_o_last;

endmodule
`default_nettype wire

// File: design/wrd_ram.sv
// ----------------------------------------------------------------------------
// wrd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module wrd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [$clog2(DEPTH)-1:0]       i_waddr,
    input  wire logic [WIDTH-1:0]               i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]       i_raddr,
    output logic      [WIDTH-1:0]               o_rdata
);
    import wrd_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: design/wrd_alu.sv
// ----------------------------------------------------------------------------
// wrd_alu
// Shared index adder / subtractor with borrow out, used by the arithmetic sequence steps.
// ----------------------------------------------------------------------------
`default_nettype none
module wrd_alu #(
    parameter int INDEX_BITS = 48
) (
    input  wire logic [INDEX_BITS-1:0] i_a,
    input  wire logic [INDEX_BITS-1:0] i_b,
    input  wire logic                  i_sub,
    output logic      [INDEX_BITS-1:0] o_res,
    output logic                       o_borrow
);
    import wrd_pkg::*;

    logic [INDEX_BITS:0] sum;

    assign sum = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {{INDEX_BITS{1'b0}}, i_sub};
    assign o_res = sum[INDEX_BITS-1:0];
    // a < b when subtracting and no carry comes out
    assign o_borrow = i_sub & ~sum[INDEX_BITS];

endmodule
`default_nettype wire
